/* hdl/u8bd_pkg.sv */
// Package for the UTF-8 to byte-level token decoder.
// Word types, status codes and the inverse byte-to-unicode map.
// No dependencies.
package u8bd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CpW     = 21;
  localparam int unsigned RemW    = 2;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_TRUNC   = 3'd1;
  localparam logic [StatusW-1:0] ST_BADCONT = 3'd2;
  localparam logic [StatusW-1:0] ST_BADLEAD = 3'd3;
  localparam logic [StatusW-1:0] ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_token;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic [StatusW-1:0] status;
    logic               token_done;
  } out_word_t;

  typedef struct packed {
    logic             hit;
    logic [ByteW-1:0] raw;
  } map_res_t;

  // Result of the decode stage towards the output register
  typedef struct packed {
    logic      emit;
    out_word_t word;
  } dec_res_t;

  // Inverse byte-to-unicode map
  function automatic map_res_t map_cp(input logic [CpW-1:0] cp);
    map_res_t   r;
    logic [8:0] shifted;
    r       = '0;
    shifted = cp[8:0] - 9'd162;
    if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
        (cp >= 21'd174 && cp <= 21'd255)) begin
      r.hit = 1'b1;
      r.raw = cp[7:0];
    end else if (cp >= 21'd256 && cp <= 21'd288) begin
      r.hit = 1'b1;
      r.raw = cp[7:0];
    end else if (cp >= 21'd289 && cp <= 21'd322) begin
      r.hit = 1'b1;
      r.raw = shifted[7:0];
    end else if (cp == 21'd323) begin
      r.hit = 1'b1;
      r.raw = 8'd173;
    end
    return r;
  endfunction

endpackage

/* hdl/utf8_to_byte_level_token_decoder.sv */
// Channel   Dir  Ports                          Word
// input     in   in_valid, in_stall, in_word    in_byte, end_of_token
// result    out  out_valid, out_stall, out_word out_byte, status, token_done
//
// One byte a cycle when the result side does not stall; a byte that completes a
// result passes through the input register, then the result register.
// Sequence state is held in the decode stage and moves only when the input
// register hands its byte on, which needs a free or draining result register.
// Synchronous active-low reset clears valids and sequence state.
// Depends on u8bd_pkg, u8bd_in_reg, u8bd_decode, u8bd_out_reg.
module utf8_to_byte_level_token_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8bd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output u8bd_pkg::out_word_t out_word
);

  logic               s_valid;
  u8bd_pkg::in_word_t s_word;
  u8bd_pkg::dec_res_t res;
  logic               free;
  logic               adv;

  assign adv = s_valid && free;

  u8bd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .adv      (adv),
    .s_valid  (s_valid),
    .s_word   (s_word)
  );

  u8bd_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .s_word (s_word),
    .res    (res)
  );

  u8bd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hdl/u8bd_in_reg.sv */
// Input register of the token decoder with its handshake.
// Depends on u8bd_pkg.
module u8bd_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8bd_pkg::in_word_t  in_word,
  input  logic                adv,
  output logic                s_valid,
  output u8bd_pkg::in_word_t  s_word
);

  logic               valid_r, valid_nxt;
  u8bd_pkg::in_word_t word_r;
  logic               take;

  assign in_stall  = valid_r && !adv;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= in_word;
    end
  end

  assign s_valid = valid_r;
  assign s_word  = word_r;

endmodule

/* hdl/u8bd_decode.sv */
// UTF-8 sequence assembly, error checks and inverse byte map.
// Holds the running sequence state; depends on u8bd_pkg.
module u8bd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  u8bd_pkg::in_word_t  s_word,
  output u8bd_pkg::dec_res_t  res
);

  logic [u8bd_pkg::RemW-1:0] rem_r, rem_nxt;
  logic [u8bd_pkg::CpW-1:0]  acc_r, acc_nxt;
  logic                      bad_r, bad_nxt;
  logic                      drop_r, drop_nxt;

  logic [7:0]                     b;
  logic                           eot;
  logic                           err;
  logic [u8bd_pkg::StatusW-1:0]   err_code;
  logic                           complete;
  logic [u8bd_pkg::CpW-1:0]       cp;
  u8bd_pkg::map_res_t             mres;

  assign b   = s_word.in_byte;
  assign eot = s_word.end_of_token;

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    bad_nxt  = bad_r;
    drop_nxt = drop_r;
    err      = 1'b0;
    err_code = u8bd_pkg::ST_OK;
    complete = 1'b0;
    cp       = '0;
    mres     = '0;
    res      = '0;

    if (drop_r) begin
      if (eot) begin
        drop_nxt = 1'b0;
      end
    end else begin
      if (rem_r == '0) begin
        bad_nxt = 1'b0;
        if (!b[7]) begin
          cp       = {13'd0, b};
          complete = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          acc_nxt = {16'd0, b[4:0]};
          rem_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_nxt = {17'd0, b[3:0]};
          rem_nxt = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_nxt = {18'd0, b[2:0]};
          rem_nxt = 2'd3;
        end else begin
          err      = 1'b1;
          err_code = u8bd_pkg::ST_BADLEAD;
        end
      end else begin
        // any byte counts as a continuation; a bad one is only noted
        bad_nxt = bad_r || (b[7:6] != 2'b10);
        acc_nxt = {acc_r[u8bd_pkg::CpW-7:0], b[5:0]};
        rem_nxt = rem_r - 2'd1;
        if (rem_nxt == '0) begin
          if (bad_nxt) begin
            err      = 1'b1;
            err_code = u8bd_pkg::ST_BADCONT;
          end else begin
            cp       = acc_nxt;
            complete = 1'b1;
          end
        end
      end

      if (!err && rem_nxt != '0 && eot) begin
        err      = 1'b1;
        err_code = u8bd_pkg::ST_TRUNC;
      end

      mres = u8bd_pkg::map_cp(cp);
      if (complete) begin
        acc_nxt = '0;
        bad_nxt = 1'b0;
        if (!mres.hit) begin
          err      = 1'b1;
          err_code = u8bd_pkg::ST_UNKNOWN;
        end else begin
          res.emit            = 1'b1;
          res.word.out_byte   = mres.raw;
          res.word.status     = u8bd_pkg::ST_OK;
          res.word.token_done = eot;
        end
      end

      if (err) begin
        rem_nxt             = '0;
        acc_nxt             = '0;
        bad_nxt             = 1'b0;
        drop_nxt            = !eot;
        res.emit            = 1'b1;
        res.word.out_byte   = '0;
        res.word.status     = err_code;
        res.word.token_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      acc_r  <= '0;
      bad_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (adv) begin
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

/* hdl/u8bd_out_reg.sv */
// Result register of the token decoder.
// Depends on u8bd_pkg.
module u8bd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  u8bd_pkg::dec_res_t  res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output u8bd_pkg::out_word_t out_word
);

  logic                valid_r, valid_nxt;
  u8bd_pkg::out_word_t word_r;
  logic                load;

  assign free      = !valid_r || !out_stall;
  assign load      = adv && res.emit;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res.word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
